>>> hw/rtl/uole_pkg.sv
// ----------------------------------------------------------------------------
// uole_pkg
// Shared types and codes of the ordered unique-value list engine.
// ----------------------------------------------------------------------------
package uole_pkg;

  // action codes
  localparam logic [2:0] ACT_FIND      = 3'd0;
  localparam logic [2:0] ACT_INS_HEAD  = 3'd1;
  localparam logic [2:0] ACT_INS_TAIL  = 3'd2;
  localparam logic [2:0] ACT_INS_AFTER = 3'd3;
  localparam logic [2:0] ACT_REMOVE    = 3'd4;
  localparam logic [2:0] ACT_CLEAR     = 3'd5;
  localparam logic [2:0] ACT_READ      = 3'd6;
  // spare code, leaves the list as it is
  localparam logic [2:0] ACT_SPARE     = 3'd7;

  // status codes
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_DUP_OR_ABSENT = 3'd1;
  localparam logic [2:0] ST_NO_ANCHOR     = 3'd2;
  localparam logic [2:0] ST_FULL          = 3'd3;
  localparam logic [2:0] ST_RANGE         = 3'd4;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] item_value;
    logic signed [31:0] anchor_value;
    logic [3:0]         position;
  } item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               found;
    logic signed [31:0] read_value;
    logic [4:0]         entry_count;
  } result_t;

  // what the action does once the scan is over
  typedef enum logic [2:0] {
    PLAN_NONE  = 3'd0,
    PLAN_INS   = 3'd1,
    PLAN_REM   = 3'd2,
    PLAN_READ  = 3'd3,
    PLAN_CLEAR = 3'd4
  } plan_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_rd;
    logic scan_cmp;
    logic decide;
    logic ins_rd;
    logic ins_wr;
    logic ins_put;
    logic rem_rd;
    logic rem_wr;
    logic rem_fin;
    logic pos_rd;
    logic pos_take;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic  scan_end;
    logic  ins_end;
    logic  rem_end;
    plan_e plan;
  } sts_t;

endpackage

>>> hw/rtl/unique_ordered_list_engine_unit.sv
// ----------------------------------------------------------------------------
// unique_ordered_list_engine_unit
// Ordered list of distinct signed 32-bit values with find, insert, remove,
// clear and read-at actions, one result beat per action.
// ----------------------------------------------------------------------------
//   channel   | signals              | handshake
//   ----------+----------------------+----------------------------------
//   action in | start, busy, in_i    | taken when start high, busy low
//   result    | done_o, result_o     | one cycle strobe, no back-pressure
//
// An action scans the list, reading each stored entry from memory and then
// comparing it; then an insert or remove shifts entries, reading and then
// writing each moved entry. Read-at scans, then reads the entry at the
// given position. The single-port list memory sets the pace.
// Reset clears the count; list memory contents are not cleared.
// The result beat cannot be stalled; the next action is taken after it.
module unique_ordered_list_engine_unit
  import uole_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   in_i,
  output logic    done_o,
  output result_t result_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  uole_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // list storage and compare
  uole_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .in_i   (in_i),
    .res_o  (result_o)
  );

  // one result beat per action
  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_taken_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted action did not start");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result beat outside an action");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.found) |-> (result_o.status == ST_OK))
    else $error("found flag with error status");

endmodule

>>> hw/rtl/uole_dp.sv
// ----------------------------------------------------------------------------
// uole_dp
// List memory, scan compare, shift moves and result registers.
// ----------------------------------------------------------------------------
module uole_dp
  import uole_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    cmd_i,
  output sts_t    sts_o,
  input  item_t   in_i,
  output result_t res_o
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 4) ? CW + 1 : 5;

  logic [31:0] mem [CAPACITY];

  logic [2:0]   act_q;
  logic [31:0]  item_q, anchor_q;
  logic [3:0]   pos_q;
  logic [CW-1:0] idx_q, len_q, ipos_q, apos_q, ins_at_q;
  logic          ihit_q, ahit_q;
  logic [31:0]  rdata_q, rval_q;
  logic [2:0]   status_q;
  logic          found_q;

  logic [2:0]    st;
  plan_e         plan;
  logic [CW-1:0] ins_at;
  logic          full, pos_ok;
  logic          rd_en, wr_en;
  logic [IW-1:0] raddr;
  logic [31:0]  wdata;

  assign full   = (len_q == CW'(CAPACITY));
  assign pos_ok = (PW'(pos_q) < PW'(len_q)) && (PW'(pos_q) < PW'(CAPACITY));

  // outcome of the action from the scan results
  always_comb begin
    plan   = PLAN_NONE;
    st     = ST_OK;
    ins_at = len_q;
    case (act_q)
      ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_AFTER: begin
        if (ihit_q) begin
          st = ST_DUP_OR_ABSENT;
        end else if (act_q == ACT_INS_AFTER && !ahit_q) begin
          st = ST_NO_ANCHOR;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          plan = PLAN_INS;
          if (act_q == ACT_INS_HEAD) begin
            ins_at = '0;
          end else if (act_q == ACT_INS_AFTER) begin
            ins_at = CW'(apos_q + CW'(1));
          end
        end
      end
      ACT_REMOVE: begin
        if (ihit_q) plan = PLAN_REM;
        else st = ST_DUP_OR_ABSENT;
      end
      ACT_CLEAR: plan = PLAN_CLEAR;
      ACT_READ: begin
        if (pos_ok) plan = PLAN_READ;
        else st = ST_RANGE;
      end
      default: ;
    endcase
  end

  assign sts_o.scan_end = (idx_q == len_q);
  assign sts_o.ins_end  = (idx_q == ins_at_q);
  assign sts_o.rem_end  = (CW'(idx_q + CW'(1)) == len_q);
  assign sts_o.plan     = plan;

  // memory port address and data select
  always_comb begin
    rd_en = cmd_i.scan_rd | cmd_i.ins_rd | cmd_i.rem_rd | cmd_i.pos_rd;
    raddr = IW'(idx_q);
    if (cmd_i.ins_rd) raddr = IW'(idx_q - CW'(1));
    else if (cmd_i.rem_rd) raddr = IW'(idx_q + CW'(1));
    else if (cmd_i.pos_rd) raddr = IW'(pos_q);
    wr_en = cmd_i.ins_wr | cmd_i.rem_wr | cmd_i.ins_put;
    wdata = cmd_i.ins_put ? item_q : rdata_q;
  end

  // list memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[IW'(idx_q)] <= wdata;
    if (rd_en) rdata_q <= mem[raddr];
  end

  // entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cmd_i.decide && plan == PLAN_CLEAR) begin
      len_q <= '0;
    end else if (cmd_i.ins_put) begin
      len_q <= CW'(len_q + CW'(1));
    end else if (cmd_i.rem_fin) begin
      len_q <= CW'(len_q - CW'(1));
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q    <= in_i.action;
      item_q   <= in_i.item_value;
      anchor_q <= in_i.anchor_value;
      pos_q    <= in_i.position;
      idx_q    <= '0;
      ihit_q   <= 1'b0;
      ahit_q   <= 1'b0;
    end
    if (cmd_i.scan_cmp) begin
      if (rdata_q == item_q) begin
        ihit_q <= 1'b1;
        ipos_q <= idx_q;
      end
      if (rdata_q == anchor_q) begin
        ahit_q <= 1'b1;
        apos_q <= idx_q;
      end
      idx_q <= CW'(idx_q + CW'(1));
    end
    if (cmd_i.decide) begin
      status_q <= st;
      found_q  <= (act_q == ACT_FIND) && ihit_q;
      rval_q   <= '0;
      ins_at_q <= ins_at;
      idx_q    <= (plan == PLAN_REM) ? ipos_q : len_q;
    end
    if (cmd_i.ins_wr) idx_q <= CW'(idx_q - CW'(1));
    if (cmd_i.rem_wr) idx_q <= CW'(idx_q + CW'(1));
    if (cmd_i.pos_take) rval_q <= rdata_q;
  end

  assign res_o.status      = status_q;
  assign res_o.found       = found_q;
  assign res_o.read_value  = rval_q;
  assign res_o.entry_count = 5'(len_q);

endmodule

>>> hw/rtl/uole_ctrl.sv
// ----------------------------------------------------------------------------
// uole_ctrl
// Sequencer: scan, decide, shift or read, then one result beat.
// ----------------------------------------------------------------------------
module uole_ctrl
  import uole_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  output logic done_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_SCAN_RD  = 11'b00000000010,
    S_SCAN_CMP = 11'b00000000100,
    S_DECIDE   = 11'b00000001000,
    S_INS_CHK  = 11'b00000010000,
    S_INS_WR   = 11'b00000100000,
    S_REM_CHK  = 11'b00001000000,
    S_REM_WR   = 11'b00010000000,
    S_RD_ISSUE = 11'b00100000000,
    S_RD_TAKE  = 11'b01000000000,
    S_DONE     = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts_i.scan_end) begin
          state_d = S_DECIDE;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d       = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        cmd_o.scan_cmp = 1'b1;
        state_d        = S_SCAN_RD;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        case (sts_i.plan)
          PLAN_INS:  state_d = S_INS_CHK;
          PLAN_REM:  state_d = S_REM_CHK;
          PLAN_READ: state_d = S_RD_ISSUE;
          default:   state_d = S_DONE;
        endcase
      end
      S_INS_CHK: begin
        if (sts_i.ins_end) begin
          cmd_o.ins_put = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.ins_rd = 1'b1;
          state_d      = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd_o.ins_wr = 1'b1;
        state_d      = S_INS_CHK;
      end
      S_REM_CHK: begin
        if (sts_i.rem_end) begin
          cmd_o.rem_fin = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.rem_rd = 1'b1;
          state_d      = S_REM_WR;
        end
      end
      S_REM_WR: begin
        cmd_o.rem_wr = 1'b1;
        state_d      = S_REM_CHK;
      end
      S_RD_ISSUE: begin
        cmd_o.pos_rd = 1'b1;
        state_d      = S_RD_TAKE;
      end
      S_RD_TAKE: begin
        cmd_o.pos_take = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule
